// ===== rtl/core/lidar_scan_frame_parser_defines.svh =====
// Assertion macros for the lidar scan frame parser.
`ifndef LIDAR_SCAN_FRAME_PARSER_DEFINES_SVH
`define LIDAR_SCAN_FRAME_PARSER_DEFINES_SVH

// Checks that cons holds in the same cycle as ante.
`define LSFP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lidar scan frame parser: same-cycle check failed");

// Checks that cons holds in the cycle after ante.
`define LSFP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lidar scan frame parser: next-cycle check failed");

`endif

// ===== rtl/core/lsfp_pkg.sv =====
package lsfp_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h55;

  localparam int unsigned POS_W = 10;

  localparam logic [POS_W-1:0] POS_TYPE    = 10'd2;
  localparam logic [POS_W-1:0] POS_COUNT   = 10'd3;
  localparam logic [POS_W-1:0] POS_START   = 10'd5;
  localparam logic [POS_W-1:0] POS_END     = 10'd7;
  localparam logic [POS_W-1:0] HDR_LEN     = 10'd10;

endpackage

// ===== rtl/core/lidar_scan_frame_parser.sv =====
// Byte-serial lidar scan packet parser. It takes one byte per clock while
// in_stall is low and gives at most one result per clock, so a byte can be
// transferred in every cycle unless stalled. A transferred byte is held in the
// input register, and any result it yields is then registered into the result
// register, which presents it until it is taken. The only limit on rate is the
// result register: in_stall rises when the input register holds a byte while a
// finished result is stalled at the output.
`include "lidar_scan_frame_parser_defines.svh"

module lidar_scan_frame_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        sample_valid,
  output logic [7:0]  sample_index,
  output logic [15:0] range_raw,
  output logic [7:0]  packet_type,
  output logic [7:0]  point_count,
  output logic [15:0] first_angle_raw,
  output logic [15:0] last_angle_raw,
  output logic        last_of_packet,
  output logic        checksum_ok
);

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_SEEN,
    PH_PACKET
  } phase_t;

  phase_t                         sync_phase, sync_phase_next;
  logic [lsfp_pkg::POS_W-1:0]     byte_position, byte_position_next;
  logic [7:0]                     held_type, held_type_next;
  logic [7:0]                     held_count, held_count_next;
  logic [15:0]                    held_first_angle, held_first_angle_next;
  logic [15:0]                    held_last_angle, held_last_angle_next;
  logic [15:0]                    received_checksum, received_checksum_next;
  logic [15:0]                    running_xor, running_xor_next;
  logic [7:0]                     low_byte_hold, low_byte_hold_next;
  logic [7:0]                     samples_emitted, samples_emitted_next;

  logic        byte_vld;
  logic [7:0]  byte_q;
  logic        advance;
  logic        hit;
  logic [15:0] word;
  logic [15:0] xor_upd;
  logic [7:0]  idx_inc;

  logic        res_vld;
  logic        res_sample;
  logic [7:0]  res_index;
  logic [15:0] res_dist;
  logic        res_last;
  logic        res_ok;

  assign advance  = !out_valid || !out_stall;
  assign in_stall = byte_vld && !advance;
  assign hit      = byte_vld && advance;
  assign word     = {byte_q, low_byte_hold};
  assign xor_upd  = running_xor ^ word;
  assign idx_inc  = samples_emitted + 8'd1;

  always_comb begin
    sync_phase_next        = sync_phase;
    byte_position_next     = byte_position;
    held_type_next         = held_type;
    held_count_next        = held_count;
    held_first_angle_next  = held_first_angle;
    held_last_angle_next   = held_last_angle;
    received_checksum_next = received_checksum;
    running_xor_next       = running_xor;
    low_byte_hold_next     = low_byte_hold;
    samples_emitted_next   = samples_emitted;
    res_vld    = 1'b0;
    res_sample = 1'b0;
    res_index  = 8'd0;
    res_dist   = 16'd0;
    res_last   = 1'b0;
    res_ok     = 1'b0;
    if (hit) begin
      unique case (sync_phase)
        PH_SEEN: begin
          if (byte_q == lsfp_pkg::HDR_SECOND) begin
            sync_phase_next      = PH_PACKET;
            byte_position_next   = lsfp_pkg::POS_TYPE;
            running_xor_next     = {lsfp_pkg::HDR_SECOND, lsfp_pkg::HDR_FIRST};
            samples_emitted_next = 8'd0;
          end else if (byte_q != lsfp_pkg::HDR_FIRST) begin
            sync_phase_next = PH_HUNT;
          end
        end
        PH_PACKET: begin
          byte_position_next = byte_position + 1'b1;
          if (!byte_position[0]) begin
            low_byte_hold_next = byte_q;
            if (byte_position == lsfp_pkg::POS_TYPE) begin
              held_type_next = byte_q;
            end
          end else if (byte_position < lsfp_pkg::HDR_LEN) begin
            case (byte_position)
              lsfp_pkg::POS_COUNT: begin
                held_count_next  = byte_q;
                running_xor_next = xor_upd;
              end
              lsfp_pkg::POS_START: begin
                held_first_angle_next = word;
                running_xor_next      = xor_upd;
              end
              lsfp_pkg::POS_END: begin
                held_last_angle_next = word;
                running_xor_next     = xor_upd;
              end
              default: begin
                received_checksum_next = word;
                if (held_count == 8'd0) begin
                  res_vld         = 1'b1;
                  res_last        = 1'b1;
                  res_ok          = (running_xor == word);
                  sync_phase_next = PH_HUNT;
                end
              end
            endcase
          end else begin
            running_xor_next     = xor_upd;
            samples_emitted_next = idx_inc;
            res_vld    = 1'b1;
            res_sample = 1'b1;
            res_index  = samples_emitted;
            res_dist   = word;
            res_last   = (idx_inc == held_count);
            res_ok     = res_last && (xor_upd == received_checksum);
            if (res_last) begin
              sync_phase_next = PH_HUNT;
            end
          end
        end
        default: begin
          sync_phase_next = (byte_q == lsfp_pkg::HDR_FIRST) ? PH_SEEN : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_phase        <= PH_HUNT;
      byte_position     <= '0;
      held_type         <= '0;
      held_count        <= '0;
      held_first_angle  <= '0;
      held_last_angle   <= '0;
      received_checksum <= '0;
      running_xor       <= '0;
      low_byte_hold     <= '0;
      samples_emitted   <= '0;
      byte_vld          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      sync_phase        <= sync_phase_next;
      byte_position     <= byte_position_next;
      held_type         <= held_type_next;
      held_count        <= held_count_next;
      held_first_angle  <= held_first_angle_next;
      held_last_angle   <= held_last_angle_next;
      received_checksum <= received_checksum_next;
      running_xor       <= running_xor_next;
      low_byte_hold     <= low_byte_hold_next;
      samples_emitted   <= samples_emitted_next;
      if (!in_stall) begin
        byte_vld <= in_valid;
      end
      if (advance) begin
        out_valid <= res_vld;
      end
    end
    if (!in_stall && in_valid) begin
      byte_q <= rx_byte;
    end
    if (advance && res_vld) begin
      sample_valid    <= res_sample;
      sample_index    <= res_index;
      range_raw       <= res_dist;
      packet_type     <= held_type;
      point_count     <= held_count;
      first_angle_raw <= held_first_angle;
      last_angle_raw  <= held_last_angle;
      last_of_packet  <= res_last;
      checksum_ok     <= res_ok;
    end
  end

  `LSFP_ASSERT_SAME(a_ok_only_last, out_valid && checksum_ok, last_of_packet)
  `LSFP_ASSERT_SAME(a_empty_packet, out_valid && !sample_valid,
                    last_of_packet && sample_index == 8'd0 && range_raw == 16'd0)
  `LSFP_ASSERT_SAME(a_last_index, out_valid && sample_valid && last_of_packet,
                    sample_index == 8'(point_count - 8'd1))
  `LSFP_ASSERT_SAME(a_packet_pos, sync_phase == PH_PACKET,
                    byte_position >= lsfp_pkg::POS_TYPE)
  `LSFP_ASSERT_NEXT(a_input_hold, byte_vld && !advance, byte_vld && $stable(byte_q))

endmodule
